// ----- hw/rtl/motor_hil_tick_engine_core_defines.svh -----
// Assertion macros shared by the motor tick engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MOTOR_HIL_TICK_ENGINE_CORE_DEFINES_SVH
`define MOTOR_HIL_TICK_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHTE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHTE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mhte_pkg.sv -----
// Shared types, constants and the sine table builder for the motor tick engine.
// Depends on nothing; used by the interfaces and the core.
package mhte_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned VOLT_W  = 17;
  localparam int unsigned SPEED_W = 32;
  localparam int unsigned DUTY_W  = 16;

  // Full scale of +-12 V in units of 1/4096 V.
  localparam int unsigned VOLT_FULL = 49152;

  // floor(y / 3) for y below 2^18 is (y * PWM_RECIP) >> PWM_RECIP_SHIFT.
  localparam logic [17:0] PWM_RECIP       = 18'd174763;
  localparam int unsigned PWM_RECIP_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_MODE        = 3'd0,
    CFG_COEF_INPUT       = 3'd1,
    CFG_COEF_OLDER_SPEED = 3'd2,
    CFG_COEF_LAST_SPEED  = 3'd3,
    CFG_TIME_STEP        = 3'd4,
    CFG_PWM_PERIOD       = 3'd5,
    CFG_VELOCITY_SCALE   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WAVE_HOLD = 2'd0,
    WAVE_SINE = 2'd1,
    WAVE_RAMP = 2'd2
  } wave_mode_e;

  // Odd polynomial coefficients of the quarter-wave sine, Q30.
  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598668;
  localparam longint unsigned SIN_C5 = 64'd85569306;
  localparam longint unsigned SIN_C7 = 64'd5026995;
  localparam longint unsigned SIN_C9 = 64'd172272;

  // One quarter-wave table entry: round(49152 * sin(pi/2 * r / 2^qb)), limited
  // to full scale. Evaluated only at elaboration.
  function automatic logic [15:0] sine_entry(input int unsigned r, input int unsigned qb);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned v;
    u  = 64'(r) << (30 - qb);
    u2 = (u * u) >> 30;
    p  = SIN_C9;
    p  = SIN_C7 - ((u2 * p) >> 30);
    p  = SIN_C5 - ((u2 * p) >> 30);
    p  = SIN_C3 - ((u2 * p) >> 30);
    p  = SIN_C1 - ((u2 * p) >> 30);
    s  = (u * p) >> 30;
    v  = (s * 64'(VOLT_FULL) + (64'd1 << 29)) >> 30;
    if (v > 64'(VOLT_FULL)) begin
      v = 64'(VOLT_FULL);
    end
    return v[15:0];
  endfunction

endpackage

// ----- hw/rtl/mhte_tick_if.sv -----
// Input channel of the motor tick engine: one encoder sample word per tick.
// Depends on mhte_pkg for field widths.
interface mhte_tick_if;
  logic                             valid;
  logic                             ready;
  logic [mhte_pkg::COUNT_W-1:0]     shaft_count;

  modport source (output valid, output shaft_count, input ready);
  modport sink   (input valid, input shaft_count, output ready);
endinterface

// ----- hw/rtl/mhte_result_if.sv -----
// Result channel of the motor tick engine: one result word per tick.
// Depends on mhte_pkg for field widths.
interface mhte_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhte_pkg::VOLT_W-1:0]  drive_voltage;
  logic signed [mhte_pkg::SPEED_W-1:0] model_speed;
  logic [mhte_pkg::DUTY_W-1:0]         pwm_duty;
  logic                                forward;
  logic signed [mhte_pkg::SPEED_W-1:0] measured_speed;

  modport source (output valid, output drive_voltage, output model_speed,
                  output pwm_duty, output forward, output measured_speed, input ready);
  modport sink   (input valid, input drive_voltage, input model_speed,
                  input pwm_duty, input forward, input measured_speed, output ready);
endinterface

// ----- hw/rtl/motor_hil_tick_engine_core.sv -----
// Motor hardware-in-the-loop tick engine: waveform, motor model, PWM and encoder speed.
// Depends on mhte_pkg, mhte_tick_if, mhte_result_if and the assertion macro header.

// The engine takes one encoder sample word per tick and returns one result word
// per tick. It sustains one tick per clock cycle while the result side is not
// stalled; each tick moves from the input register through the model stage into
// the result register, which presents its result word. The speed recurrence
// closes combinationally from the speed history registers back into them,
// through three parallel signed multipliers and one wide rounding adder, which
// is what sets the clock. Each stage holds its word while the next one is full,
// so the input keeps accepting until all three stages are occupied. The drive
// voltage is a 12 V 1 Hz sine taken from a quarter-wave constant table, a ramp
// that starts at one second, or the previous voltage held; the motor model uses
// the voltage of the previous tick. Configuration registers may only be written
// while no tick is in flight. There is no clearing pass after reset.
`include "motor_hil_tick_engine_core_defines.svh"

module motor_hil_tick_engine_core #(
  parameter int unsigned SINE_TABLE_BITS = mhte_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mhte_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mhte_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  mhte_tick_if.sink                        tick_i,
  mhte_result_if.source                    result_o
);
  import mhte_pkg::*;

  // Quarter-wave table: entries 0 .. 2^QB inclusive, since the reflected index
  // reaches the peak exactly.
  localparam int unsigned QB    = SINE_TABLE_BITS - 2;
  localparam int unsigned QSIZE = (2 ** QB) + 1;

  typedef logic [15:0] sine_lut_t [QSIZE];

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int unsigned i = 0; i < QSIZE; i++) begin
      lut[i] = sine_entry(i, QB);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]                 wave_mode_q;
  logic signed [31:0]         coef_input_q;
  logic signed [31:0]         coef_older_q;
  logic signed [31:0]         coef_last_q;
  logic [15:0]                time_step_q;
  logic [15:0]                pwm_period_q;
  logic [23:0]                vel_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_mode_q  <= WAVE_SINE;
      coef_input_q <= '0;
      coef_older_q <= '0;
      coef_last_q  <= '0;
      time_step_q  <= 16'd655;
      pwm_period_q <= '0;
      vel_scale_q  <= 24'd41175;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WAVE_MODE:        wave_mode_q  <= cfg_wdata_i[1:0];
        CFG_COEF_INPUT:       coef_input_q <= cfg_wdata_i;
        CFG_COEF_OLDER_SPEED: coef_older_q <= cfg_wdata_i;
        CFG_COEF_LAST_SPEED:  coef_last_q  <= cfg_wdata_i;
        CFG_TIME_STEP:        time_step_q  <= cfg_wdata_i[15:0];
        CFG_PWM_PERIOD:       pwm_period_q <= cfg_wdata_i[15:0];
        CFG_VELOCITY_SCALE:   vel_scale_q  <= cfg_wdata_i[23:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: input register, model stage, result register
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, res_valid_q;
  logic res_free, s2_free, s1_adv, s2_adv;

  assign res_free     = !res_valid_q || result_o.ready;
  assign s2_adv       = s2_valid_q && res_free;
  assign s2_free      = !s2_valid_q || res_free;
  assign s1_adv       = s1_valid_q && s2_free;
  assign tick_i.ready = !s1_valid_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (tick_i.ready) begin
        s1_valid_q <= tick_i.valid;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (res_free) begin
        res_valid_q <= s2_valid_q;
      end
    end
  end

  logic [COUNT_W-1:0] s1_count_q;

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      s1_count_q <= tick_i.shaft_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick state
  // ---------------------------------------------------------------------------
  logic signed [VOLT_W-1:0]  prev_voltage_q, volt_d;
  logic signed [SPEED_W-1:0] speed_last_q, speed_before_q, speed_d;
  logic [COUNT_W-1:0]        prev_count_q;
  logic [31:0]               elapsed_q, elapsed_d;

  // Sine lookup. The phase is the fractional second, cut to the table's bits;
  // odd quadrants read the table mirrored and the second half turn is negated.
  logic [SINE_TABLE_BITS-1:0] phase;
  logic [1:0]                 quad;
  logic [QB:0]                sine_idx;
  logic [15:0]                sine_mag;
  logic signed [VOLT_W-1:0]   sine_v;

  assign phase    = elapsed_q[15 -: SINE_TABLE_BITS];
  assign quad     = phase[SINE_TABLE_BITS-1 -: 2];
  assign sine_idx = quad[0] ? ({1'b1, {QB{1'b0}}} - {1'b0, phase[QB-1:0]})
                            : {1'b0, phase[QB-1:0]};
  assign sine_mag = SINE_LUT[sine_idx];
  assign sine_v   = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

  // Ramp: (t - 1 s) / 16 in 1/4096 V once a second has passed, limited to 12 V.
  logic [15:0]             ramp_sec;
  logic [27:0]             ramp_raw;
  logic signed [VOLT_W-1:0] ramp_v;

  assign ramp_sec = elapsed_q[31:16] - 16'd1;
  assign ramp_raw = {ramp_sec, elapsed_q[15:4]};

  always_comb begin
    if (elapsed_q[31:16] == 16'd0) begin
      ramp_v = '0;
    end else if (ramp_raw > 28'(VOLT_FULL)) begin
      ramp_v = VOLT_W'(VOLT_FULL);
    end else begin
      ramp_v = $signed(ramp_raw[VOLT_W-1:0]);
    end
  end

  // Every source is already within +-12 V, so the selection is the clamped
  // voltage. The unused mode code holds, as hold mode does.
  always_comb begin
    unique case (wave_mode_e'(wave_mode_q))
      WAVE_SINE: volt_d = sine_v;
      WAVE_RAMP: volt_d = ramp_v;
      default:   volt_d = prev_voltage_q;
    endcase
  end

  // Motor difference equation on the previous tick's voltage. The exact sum at
  // scale 2^-28 is rounded half up and saturated to 32 bits.
  logic signed [48:0] prod_in;
  logic signed [63:0] prod_older, prod_last;
  logic signed [65:0] model_acc;
  logic signed [37:0] model_rnd;

  assign prod_in    = 49'(coef_input_q) * 49'(prev_voltage_q);
  assign prod_older = 64'(coef_older_q) * 64'(speed_before_q);
  assign prod_last  = 64'(coef_last_q) * 64'(speed_last_q);
  assign model_acc  = $signed({{13{prod_in[48]}}, prod_in, 4'b0000})
                    - $signed({{2{prod_older[63]}}, prod_older})
                    - $signed({{2{prod_last[63]}}, prod_last})
                    + $signed(66'd134217728);
  assign model_rnd  = model_acc[65:28];

  always_comb begin
    if (model_rnd[37:31] == {7{model_rnd[31]}}) begin
      speed_d = model_rnd[31:0];
    end else if (model_rnd[37]) begin
      speed_d = {1'b1, {31{1'b0}}};
    end else begin
      speed_d = {1'b0, {31{1'b1}}};
    end
  end

  // Encoder speed from the wrapped 16-bit count delta.
  logic signed [COUNT_W-1:0] count_delta;
  logic signed [40:0]        meas_full;
  logic signed [SPEED_W-1:0] meas_d;

  assign count_delta = s1_count_q - prev_count_q;
  assign meas_full   = 41'(count_delta) * 41'($signed({1'b0, vel_scale_q}));

  always_comb begin
    if (meas_full[40:31] == {10{meas_full[31]}}) begin
      meas_d = meas_full[31:0];
    end else if (meas_full[40]) begin
      meas_d = {1'b1, {31{1'b0}}};
    end else begin
      meas_d = {1'b0, {31{1'b1}}};
    end
  end

  // Time advances by one tick and sticks at its maximum.
  logic [32:0] time_sum;

  assign time_sum  = {1'b0, elapsed_q} + {17'd0, time_step_q};
  assign elapsed_d = time_sum[32] ? '1 : time_sum[31:0];

  // PWM magnitude times period; the division by full scale follows a stage later.
  logic [VOLT_W-1:0] volt_abs;
  logic [31:0]       pwm_prod_d;

  assign volt_abs   = volt_d[VOLT_W-1] ? VOLT_W'(-volt_d) : VOLT_W'(volt_d);
  assign pwm_prod_d = 32'(volt_abs[15:0]) * 32'(pwm_period_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_voltage_q <= '0;
      speed_last_q   <= '0;
      speed_before_q <= '0;
      prev_count_q   <= '0;
      elapsed_q      <= '0;
    end else if (s1_adv) begin
      prev_voltage_q <= volt_d;
      speed_last_q   <= speed_d;
      speed_before_q <= speed_last_q;
      prev_count_q   <= s1_count_q;
      elapsed_q      <= elapsed_d;
    end
  end

  // Model stage. The word in this stage is always the last one to have updated
  // the tick state, so its voltage and model speed are read from that state.
  logic [31:0]               s2_pwm_prod_q;
  logic signed [SPEED_W-1:0] s2_meas_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_pwm_prod_q <= pwm_prod_d;
      s2_meas_q     <= meas_d;
    end
  end

  // Division by 49152 = 3 * 2^14: drop 14 bits, then divide by 3 through a
  // reciprocal that is exact for all 18-bit values.
  logic [17:0] pwm_div_in;
  logic [35:0] pwm_div_prod;
  logic [DUTY_W-1:0] duty_d;

  assign pwm_div_in   = s2_pwm_prod_q[31:14];
  assign pwm_div_prod = 36'(pwm_div_in) * 36'(PWM_RECIP);
  assign duty_d       = pwm_div_prod[PWM_RECIP_SHIFT +: DUTY_W];

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic signed [VOLT_W-1:0]  res_volt_q;
  logic signed [SPEED_W-1:0] res_speed_q;
  logic [DUTY_W-1:0]         res_duty_q;
  logic signed [SPEED_W-1:0] res_meas_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      res_volt_q  <= prev_voltage_q;
      res_speed_q <= speed_last_q;
      res_duty_q  <= duty_d;
      res_meas_q  <= s2_meas_q;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.drive_voltage  = res_volt_q;
  assign result_o.model_speed    = res_speed_q;
  assign result_o.pwm_duty       = res_duty_q;
  assign result_o.forward        = !res_volt_q[VOLT_W-1];
  assign result_o.measured_speed = res_meas_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MHTE_ASSERT_IMP(a_accept_when_drained, clk_i, rst_ni, !res_valid_q, tick_i.ready, "input stalled with empty result register")
  `MHTE_ASSERT_IMP(a_volt_in_range, clk_i, rst_ni, res_valid_q, (res_volt_q <= $signed(VOLT_W'(VOLT_FULL))) && (res_volt_q >= -$signed(VOLT_W'(VOLT_FULL))), "drive voltage beyond full scale")
  `MHTE_ASSERT_IMP(a_duty_zero_volt, clk_i, rst_ni, res_valid_q && (res_volt_q == '0), res_duty_q == '0, "nonzero duty at zero voltage")
  `MHTE_ASSERT_NXT(a_speed_shift, clk_i, rst_ni, s1_adv, speed_before_q == $past(speed_last_q), "speed history not shifted")

endmodule

// ----- tb/motor_hil_tick_engine_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for motor_hil_tick_engine_core: encoder ticks in, result words out.
// Depends on mhte_pkg, the mhte_tick_if and mhte_result_if interfaces and the core RTL.
module motor_hil_tick_engine_core_test;
  import mhte_pkg::*;

  localparam int SINE_BITS  = SINE_TABLE_BITS_DEF;
  localparam int FULL_SCALE = VOLT_FULL;
  localparam int CLK_HALF   = 6;
  localparam int NUM_REGS   = 7;

  // Mode code that the block does not name; it must behave like a hold.
  localparam logic [1:0] WAVE_UNUSED = 2'd3;

  // Kinds of register settings used by the random phases.
  localparam int PLAN_PLANT   = 0;
  localparam int PLAN_RANDOM  = 1;
  localparam int PLAN_CORNERS = 2;

  // One result word, laid out field by field as the result channel carries it.
  typedef struct packed {
    logic signed [VOLT_W-1:0]  drive_voltage;
    logic signed [SPEED_W-1:0] model_speed;
    logic [DUTY_W-1:0]         pwm_duty;
    logic                      forward;
    logic signed [SPEED_W-1:0] measured_speed;
  } tick_result_t;

  // One row of the directed sequence: either a register write or a tick, and for
  // some ticks a result word that is known without running the model.
  typedef struct packed {
    logic         is_write;
    cfg_reg_e     reg_idx;
    logic [31:0]  wdata;
    logic [15:0]  count;
    logic         has_known;
    tick_result_t known;
  } stim_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we;
  cfg_reg_e       cfg_idx;
  logic [31:0]    cfg_wdata;

  mhte_tick_if    tick_if ();
  mhte_result_if  result_if ();

  motor_hil_tick_engine_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .tick_i      (tick_if),
    .result_o    (result_if)
  );

  // Shadow copy of the configuration registers.
  logic [1:0]         mode_reg;
  logic signed [31:0] k_volt;
  logic signed [31:0] k_speed_n2;
  logic signed [31:0] k_speed_n1;
  logic [15:0]        dt_reg;
  logic [15:0]        period_reg;
  logic [23:0]        vscale_reg;

  // Shadow copy of the engine state.
  logic signed [16:0] held_volt;
  logic signed [31:0] speed_n1;
  logic signed [31:0] speed_n2;
  logic [15:0]        last_count;
  logic [31:0]        run_time;

  tick_result_t       due_outputs[$];
  stim_row_t          plan_rows[$];
  int                 stall_pct;
  int                 failures   = 0;
  int                 ticks_sent = 0;
  int                 reg_writes = 0;

  // Computes the result word of one accepted tick and advances the shadow state.
  function automatic tick_result_t advance_motor_tick(input logic [15:0] count);
    tick_result_t         res;
    int                   volt;
    int unsigned          mag;
    logic [SINE_BITS-1:0] phase;
    int unsigned          quarter;
    int unsigned          slot;
    longint unsigned      u;
    longint unsigned      u2;
    longint unsigned      poly;
    longint unsigned      s;
    longint unsigned      amp;
    logic signed [67:0]   acc;
    logic [15:0]          d16;
    logic signed [47:0]   meas;
    logic [32:0]          t_sum;

    // Drive voltage. Hold, and the unnamed mode code, repeat the last voltage.
    volt = held_volt;
    if (mode_reg == WAVE_SINE) begin
      // Top bits of the fractional second select a point of the wave; odd
      // quarters mirror the index and the second half turn flips the sign.
      phase   = run_time[15 -: SINE_BITS];
      quarter = 32'(phase[SINE_BITS-1 -: 2]);
      slot    = 32'(phase[SINE_BITS-3:0]);
      if (quarter[0]) begin
        slot = (1 << (SINE_BITS - 2)) - slot;
      end
      u    = 64'(slot) << (30 - (SINE_BITS - 2));
      u2   = (u * u) >> 30;
      poly = SIN_C9;
      poly = SIN_C7 - ((u2 * poly) >> 30);
      poly = SIN_C5 - ((u2 * poly) >> 30);
      poly = SIN_C3 - ((u2 * poly) >> 30);
      poly = SIN_C1 - ((u2 * poly) >> 30);
      s    = (u * poly) >> 30;
      amp  = (s * 64'(VOLT_FULL) + (64'd1 << 29)) >> 30;
      if (amp > 64'(VOLT_FULL)) begin
        amp = 64'(VOLT_FULL);
      end
      volt = quarter[1] ? -int'(amp) : int'(amp);
    end else if (mode_reg == WAVE_RAMP) begin
      volt = (run_time >= 32'd65536) ? int'((run_time - 32'd65536) >> 4) : 0;
    end
    if (volt > FULL_SCALE) begin
      volt = FULL_SCALE;
    end
    if (volt < -FULL_SCALE) begin
      volt = -FULL_SCALE;
    end

    // Motor recurrence on the previous voltage, summed exactly and rounded
    // half up at 2^-28.
    acc = k_volt * held_volt * 68'sd16 - k_speed_n2 * speed_n2 - k_speed_n1 * speed_n1
          + 68'sd134217728;
    acc = acc >>> 28;
    speed_n2 = speed_n1;
    if (acc > 68'sd2147483647) begin
      speed_n1 = 32'h7FFF_FFFF;
    end else if (acc < -68'sd2147483648) begin
      speed_n1 = 32'h8000_0000;
    end else begin
      speed_n1 = acc[31:0];
    end
    held_volt = volt[16:0];

    mag = (volt < 0) ? -volt : volt;

    // Encoder speed from the wrapped 16-bit delta.
    d16  = count - last_count;
    meas = $signed(d16) * $signed({1'b0, vscale_reg});
    last_count = count;

    t_sum    = {1'b0, run_time} + {17'd0, dt_reg};
    run_time = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];

    res.drive_voltage = volt[16:0];
    res.model_speed   = speed_n1;
    res.pwm_duty      = 16'((64'(mag) * period_reg) / 64'(VOLT_FULL));
    res.forward       = (volt >= 0);
    if (meas > 48'sd2147483647) begin
      res.measured_speed = 32'h7FFF_FFFF;
    end else if (meas < -48'sd2147483648) begin
      res.measured_speed = 32'h8000_0000;
    end else begin
      res.measured_speed = meas[31:0];
    end
    return res;
  endfunction

  function automatic stim_row_t write_row(input cfg_reg_e idx, input logic [31:0] data);
    stim_row_t row;
    row         = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.wdata   = data;
    return row;
  endfunction

  function automatic stim_row_t tick_row(input logic [15:0] count);
    stim_row_t row;
    row       = '0;
    row.count = count;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [15:0] count, input int volt,
                                          input logic [31:0] speed, input logic [15:0] duty,
                                          input logic fwd, input logic [31:0] meas);
    stim_row_t row;
    row                      = '0;
    row.count                = count;
    row.has_known            = 1'b1;
    row.known.drive_voltage  = volt[16:0];
    row.known.model_speed    = speed;
    row.known.pwm_duty       = duty;
    row.known.forward        = fwd;
    row.known.measured_speed = meas;
    return row;
  endfunction

  // Returns one of three corner words, or a random word a quarter of the time.
  function automatic logic [31:0] pick_corner(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c);
    case ($urandom_range(3))
      0:       return a;
      1:       return b;
      2:       return c;
      default: return $urandom;
    endcase
  endfunction

  // Writes one register at the next rising edge. The caller lowers the write
  // enable once the group of writes is done, so back-to-back writes keep it high.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_WAVE_MODE:        mode_reg   = data[1:0];
      CFG_COEF_INPUT:       k_volt     = data;
      CFG_COEF_OLDER_SPEED: k_speed_n2 = data;
      CFG_COEF_LAST_SPEED:  k_speed_n1 = data;
      CFG_TIME_STEP:        dt_reg     = data[15:0];
      CFG_PWM_PERIOD:       period_reg = data[15:0];
      CFG_VELOCITY_SCALE:   vscale_reg = data[23:0];
      default:              ;
    endcase
    reg_writes++;
  endtask

  // Stops sending and waits until every outstanding tick has produced its word.
  task automatic settle_engine();
    tick_if.valid <= 1'b0;
    while (due_outputs.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Offers one tick, with random idle cycles first, and records the expected word
  // at the edge where the block takes it. Valid stays high afterwards so that a
  // following tick can go out without a gap.
  task automatic send_tick(input logic [15:0] count, input logic has_known,
                           input tick_result_t known);
    tick_result_t predicted;
    while ($urandom_range(99) < stall_pct) begin
      tick_if.valid       <= 1'b0;
      tick_if.shaft_count <= 16'($urandom);
      @(posedge clk_i);
    end
    tick_if.valid       <= 1'b1;
    tick_if.shaft_count <= count;
    do begin
      @(posedge clk_i);
    end while (!tick_if.ready);
    predicted = advance_motor_tick(count);
    due_outputs.push_back(has_known ? known : predicted);
    ticks_sent++;
  endtask

  // One random phase: drain, write all seven registers, then send n ticks.
  // A mode or time step of -1 is chosen at random; the other bits of narrow
  // registers carry junk that the block must drop.
  task automatic run_phase(input int kind, input int n, input int mode_pin,
                           input int step_pin);
    logic [31:0] plan [NUM_REGS];
    logic [15:0] count;
    for (int i = 0; i < NUM_REGS; i++) begin
      plan[i] = $urandom;
    end
    plan[CFG_WAVE_MODE][1:0] = 2'($urandom_range(3));
    if (kind == PLAN_PLANT) begin
      // A stable plant, damped close to critically, so the speed walks through ordinary values
      // instead of pinning at the rails.
      plan[CFG_COEF_INPUT]        = 32'(int'($urandom_range(2097152)) - 1048576);
      plan[CFG_COEF_OLDER_SPEED]  = 32'(217432719 + int'($urandom_range(8388608)) - 4194304);
      plan[CFG_COEF_LAST_SPEED]   = 32'(-483183820 + int'($urandom_range(8388608)) - 4194304);
      plan[CFG_TIME_STEP][15:0]   = 16'($urandom_range(1, 2000));
      plan[CFG_PWM_PERIOD][15:0]  = 16'($urandom_range(65535));
      plan[CFG_VELOCITY_SCALE][23:0] = 24'($urandom_range(1, 100000));
    end else if (kind == PLAN_CORNERS) begin
      plan[CFG_COEF_INPUT]       = pick_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      plan[CFG_COEF_OLDER_SPEED] = pick_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      plan[CFG_COEF_LAST_SPEED]  = pick_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
      plan[CFG_TIME_STEP][15:0]  = 16'(pick_corner(32'h0, 32'hFFFF, 32'h1));
      plan[CFG_PWM_PERIOD][15:0] = 16'(pick_corner(32'h0, 32'hFFFF, 32'h1));
      plan[CFG_VELOCITY_SCALE][23:0] = 24'(pick_corner(32'h0, 32'hFF_FFFF, 32'h1));
    end
    if (mode_pin >= 0) begin
      plan[CFG_WAVE_MODE][1:0] = mode_pin[1:0];
    end
    if (step_pin >= 0) begin
      plan[CFG_TIME_STEP][15:0] = step_pin[15:0];
    end

    settle_engine();
    for (int i = 0; i < NUM_REGS; i++) begin
      write_reg(cfg_reg_e'(i), plan[i]);
    end
    cfg_we <= 1'b0;

    // Mostly a turning shaft (small deltas either way), with rests, wild samples
    // and half-range jumps that sit on the wrap of the delta.
    count = last_count;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0, 1, 2: count = 16'($urandom);
        3:       count = count + 16'h7FFF;
        4:       count = count + 16'h8000;
        5:       count = count;
        default: count = count + 16'($urandom_range(64)) - 16'd32;
      endcase
      send_tick(count, 1'b0, '0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // The result side stalls on its own schedule, sharing the idle rate of the sender.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted word is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    tick_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (due_outputs.size() == 0) begin
        $error("result word accepted with no tick outstanding");
        failures++;
      end else begin
        want = due_outputs.pop_front();
        if (result_if.drive_voltage !== want.drive_voltage) begin
          $error("drive_voltage: expected %0d, got %0d", want.drive_voltage,
                 result_if.drive_voltage);
          failures++;
        end
        if (result_if.model_speed !== want.model_speed) begin
          $error("model_speed: expected %0d, got %0d", want.model_speed,
                 result_if.model_speed);
          failures++;
        end
        if (result_if.pwm_duty !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, result_if.pwm_duty);
          failures++;
        end
        if (result_if.forward !== want.forward) begin
          $error("forward: expected %0d, got %0d", want.forward, result_if.forward);
          failures++;
        end
        if (result_if.measured_speed !== want.measured_speed) begin
          $error("measured_speed: expected %0d, got %0d", want.measured_speed,
                 result_if.measured_speed);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_WAVE_MODE;
    cfg_wdata           <= '0;
    tick_if.valid       <= 1'b0;
    tick_if.shaft_count <= '0;
    stall_pct           = 7;

    // Shadow registers and state start at the reset values of the block.
    mode_reg   = WAVE_SINE;
    k_volt     = '0;
    k_speed_n2 = '0;
    k_speed_n1 = '0;
    dt_reg     = 16'd655;
    period_reg = '0;
    vscale_reg = 24'd41175;
    held_volt  = '0;
    speed_n1   = '0;
    speed_n2   = '0;
    last_count = '0;
    run_time   = '0;

    // Directed sequence. The first tick runs on reset settings: sine at phase
    // zero, no PWM period, zero coefficients, so every field is zero except forward.
    plan_rows.push_back(known_row(16'h0000, 0, 32'h0, 16'h0, 1'b1, 32'h0));
    // Ramp before one second gives zero volts; with the clock frozen and the
    // largest speed scale, half-range count jumps must pin the measured speed
    // at both rails, and a one-count step gives the scale itself.
    plan_rows.push_back(write_row(CFG_WAVE_MODE, 32'(WAVE_RAMP)));
    plan_rows.push_back(write_row(CFG_TIME_STEP, 32'h0));
    plan_rows.push_back(write_row(CFG_VELOCITY_SCALE, 32'h00FF_FFFF));
    plan_rows.push_back(known_row(16'h7FFF, 0, 32'h0, 16'h0, 1'b1, 32'h7FFF_FFFF));
    plan_rows.push_back(known_row(16'hFFFF, 0, 32'h0, 16'h0, 1'b1, 32'h8000_0000));
    plan_rows.push_back(known_row(16'hFFFF, 0, 32'h0, 16'h0, 1'b1, 32'h0));
    plan_rows.push_back(known_row(16'h0000, 0, 32'h0, 16'h0, 1'b1, 32'h00FF_FFFF));
    // One step brings the clock from 655 to exactly one second, still in ramp.
    plan_rows.push_back(write_row(CFG_TIME_STEP, 32'd64881));
    plan_rows.push_back(known_row(16'h0000, 0, 32'h0, 16'h0, 1'b1, 32'h0));
    // Quarter-second steps land the sine on its zero crossings and both peaks,
    // where the full period gives a full-scale duty.
    plan_rows.push_back(write_row(CFG_WAVE_MODE, 32'(WAVE_SINE)));
    plan_rows.push_back(write_row(CFG_TIME_STEP, 32'd16384));
    plan_rows.push_back(write_row(CFG_PWM_PERIOD, 32'hFFFF));
    plan_rows.push_back(write_row(CFG_VELOCITY_SCALE, 32'd41175));
    plan_rows.push_back(known_row(16'h0000, 0, 32'h0, 16'h0, 1'b1, 32'h0));
    plan_rows.push_back(known_row(16'h0000, FULL_SCALE, 32'h0, 16'hFFFF, 1'b1, 32'h0));
    plan_rows.push_back(known_row(16'h0000, 0, 32'h0, 16'h0, 1'b1, 32'h0));
    plan_rows.push_back(known_row(16'h0000, -FULL_SCALE, 32'h0, 16'hFFFF, 1'b0, 32'h0));
    // Hold, and the unnamed mode code, keep the negative peak.
    plan_rows.push_back(write_row(CFG_WAVE_MODE, 32'(WAVE_HOLD)));
    plan_rows.push_back(known_row(16'h0000, -FULL_SCALE, 32'h0, 16'hFFFF, 1'b0, 32'h0));
    plan_rows.push_back(write_row(CFG_WAVE_MODE, 32'(WAVE_UNUSED)));
    plan_rows.push_back(known_row(16'h0000, -FULL_SCALE, 32'h0, 16'hFFFF, 1'b0, 32'h0));
    // Extreme coefficients drive the speed recurrence into saturation.
    plan_rows.push_back(write_row(CFG_COEF_INPUT, 32'h7FFF_FFFF));
    plan_rows.push_back(write_row(CFG_COEF_OLDER_SPEED, 32'h8000_0000));
    plan_rows.push_back(write_row(CFG_COEF_LAST_SPEED, 32'h8000_0000));
    plan_rows.push_back(tick_row(16'h1234));
    plan_rows.push_back(tick_row(16'h1200));
    plan_rows.push_back(tick_row(16'h9200));
    plan_rows.push_back(tick_row(16'h1201));
    // Ramp with the longest step climbs steeply but stays below the clamp over these six ticks.
    plan_rows.push_back(write_row(CFG_WAVE_MODE, 32'(WAVE_RAMP)));
    plan_rows.push_back(write_row(CFG_TIME_STEP, 32'hFFFF));
    for (int i = 0; i < 6; i++) begin
      plan_rows.push_back(tick_row(16'(i * 4099)));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    begin : directed_walk
      logic cfg_open;
      cfg_open = 1'b0;
      foreach (plan_rows[i]) begin
        if (plan_rows[i].is_write) begin
          if (!cfg_open) begin
            settle_engine();
            cfg_open = 1'b1;
          end
          write_reg(plan_rows[i].reg_idx, plan_rows[i].wdata);
        end else begin
          if (cfg_open) begin
            cfg_we   <= 1'b0;
            cfg_open = 1'b0;
          end
          send_tick(plan_rows[i].count, plan_rows[i].has_known, plan_rows[i].known);
        end
      end
    end

    // Random phases rotate through plant-like, fully random and corner settings;
    // one of them runs with no idling on either side.
    for (int p = 0; p < 9; p++) begin
      stall_pct = (p == 4) ? 0 : 7;
      run_phase(p % 3, 80, -1, -1);
    end
    stall_pct = 7;

    // The longest step under sine jumps across the table, then ramp and sine run
    // with the clock well past one second.
    run_phase(PLAN_PLANT, 20, WAVE_SINE, 65535);
    run_phase(PLAN_CORNERS, 20, WAVE_RAMP, -1);
    run_phase(PLAN_RANDOM, 20, WAVE_SINE, -1);

    settle_engine();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d encoder ticks and %0d register writes: hold, sine, ramp,",
             ticks_sent, reg_writes);
    $display("rail clamps, and speed and count saturation under random stalls.");
    if (failures == 0) begin
      $display("motor_hil_tick_engine_core test passed");
    end else begin
      $display("motor_hil_tick_engine_core test failed");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under 0.1 ms of simulated time.
  initial begin
    #(2_000_000);
    $display("motor_hil_tick_engine_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mhte_pkg.sv
hw/rtl/mhte_tick_if.sv
hw/rtl/mhte_result_if.sv
hw/rtl/motor_hil_tick_engine_core.sv
tb/motor_hil_tick_engine_core_test.sv
